FILE: rtl/xalu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xalu_pkg
// Shared types and constants of the integer ALU: opcodes, state encoding and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package xalu_pkg;

   localparam int unsigned DivSteps = 64;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_ADC  = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_SBB  = 5'd3;
   localparam logic [4:0] OP_MUL  = 5'd4;
   localparam logic [4:0] OP_IMUL = 5'd5;
   localparam logic [4:0] OP_DIV  = 5'd6;
   localparam logic [4:0] OP_IDIV = 5'd7;
   localparam logic [4:0] OP_MOD  = 5'd8;
   localparam logic [4:0] OP_IMOD = 5'd9;
   localparam logic [4:0] OP_AND  = 5'd10;
   localparam logic [4:0] OP_XOR  = 5'd11;
   localparam logic [4:0] OP_OR   = 5'd12;
   localparam logic [4:0] OP_SHL  = 5'd13;
   localparam logic [4:0] OP_SHR  = 5'd14;
   localparam logic [4:0] OP_SAR  = 5'd15;
   localparam logic [4:0] OP_SAL  = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_FIX,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;      // capture the item
      logic mul_step;  // form the product
      logic div_init;  // set up the divider
      logic div_step;  // one restoring step
      logic div_fix;   // apply signs
      logic finish;    // compute result and flags
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic is_mul;
      logic div_last;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/xalu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xalu_datapath
// Operand registers, product register, bit-serial divider, flag store and
// result register.
// ----------------------------------------------------------------------------
module xalu_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  xalu_pkg::cmd_type    cmd,
   output xalu_pkg::status_type status,
   input  wire  [4:0]           req_cmd,
   input  wire  [1:0]           req_operand_size,
   input  wire  [31:0]          req_src_value,
   input  wire  [63:0]          req_dest_value,
   output logic [63:0]          rsp_result_value,
   output logic                 rsp_carry_flag,
   output logic                 rsp_parity_flag,
   output logic                 rsp_zero_flag,
   output logic                 rsp_sign_flag,
   output logic                 rsp_overflow_flag,
   output logic                 rsp_divide_error
);

   logic [4:0]  op_ff;
   logic [1:0]  size_ff;
   logic [31:0] src_ff;
   logic [63:0] dst_ff;
   logic [63:0] prod_ff;         // product magnitude
   logic        mneg_ff;         // product is negative
   logic [63:0] rem_ff, rem_in;  // partial remainder
   logic [63:0] quo_ff, quo_in;  // dividend shifting out, quotient in
   logic [31:0] dvs_ff;          // divisor magnitude
   logic        dneg_ff, sneg_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] res_ff;
   logic        cf_ff, pf_ff, zf_ff, sf_ff, of_ff, de_ff;

   // width decode
   logic [63:0] m, m2;
   logic [5:0]  w;
   always_comb begin
      case (size_ff)
         2'd0:    begin m = 64'hFF;   m2 = 64'hFFFF;     w = 6'd8;  end
         2'd1:    begin m = 64'hFFFF; m2 = 64'hFFFF_FFFF; w = 6'd16; end
         default: begin m = 64'hFFFF_FFFF; m2 = '1;     w = 6'd32; end
      endcase
   end

   logic [63:0] s, d, top, sx_d, dv;
   assign s   = {32'd0, src_ff} & m;
   assign d   = dst_ff & m;
   assign top = 64'd1 << (w - 6'd1);
   assign sx_d = ((d & top) != 0) ? (d | ~m) : d;
   assign dv   = dst_ff & m2;

   logic is_signed_div, dneg, sneg;
   assign is_signed_div = (op_ff == xalu_pkg::OP_IDIV) || (op_ff == xalu_pkg::OP_IMOD);
   assign dneg = is_signed_div && (((dv >> ({w, 1'b0} - 7'd1)) & 64'd1) != 0);
   assign sneg = is_signed_div && ((s & top) != 0);

   assign status.is_div = (op_ff == xalu_pkg::OP_DIV) || (op_ff == xalu_pkg::OP_IDIV)
                       || (op_ff == xalu_pkg::OP_MOD) || (op_ff == xalu_pkg::OP_IMOD);
   assign status.is_mul = (op_ff == xalu_pkg::OP_MUL) || (op_ff == xalu_pkg::OP_IMUL);
   assign status.div_last = (cnt_ff == 6'(xalu_pkg::DivSteps - 1));

   // multiply unsigned magnitudes, signs are applied on the registered product
   logic        is_imul, mul_dneg, mul_sneg, mneg;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p, prod_v;
   always_comb begin
      is_imul  = (op_ff == xalu_pkg::OP_IMUL);
      mul_dneg = is_imul && ((d & top) != 0);
      mul_sneg = is_imul && ((s & top) != 0);
      mul_a    = mul_dneg ? 32'((64'd0 - d) & m) : d[31:0];
      mul_b    = mul_sneg ? 32'((64'd0 - s) & m) : s[31:0];
      mneg     = mul_dneg ^ mul_sneg;
   end
   assign mul_p  = mul_a * mul_b;
   assign prod_v = mneg_ff ? (64'd0 - prod_ff) : prod_ff;

   // one restoring step
   logic [64:0] trial;
   always_comb begin
      trial  = {rem_ff, quo_ff[63]} - {33'd0, dvs_ff};
      rem_in = trial[64] ? {rem_ff[62:0], quo_ff[63]} : trial[63:0];
      quo_in = {quo_ff[62:0], ~trial[64]};
   end

   // result and flag computation
   logic [63:0] r, full, sub, wide, sar_v;
   logic [4:0]  c;
   logic        cf, pf, zf, sf, of_n, de, upd_szp, upd_co;
   always_comb begin
      c = src_ff[4:0];
      r = '0; full = '0; sub = '0; wide = '0; sar_v = '0;
      cf = cf_ff; of_n = of_ff; de = 1'b0;
      upd_szp = 1'b0; upd_co = 1'b0;
      case (op_ff)
         xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
            full = d + s + {63'd0, (op_ff == xalu_pkg::OP_ADC) & cf_ff};
            r = full & m;
            cf = ((full >> w) & 64'd1) != 0;
            of_n = ((~(d ^ s)) & (d ^ r) & top) != 0;
            upd_szp = 1'b1;
         end
         xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
            sub = s + {63'd0, (op_ff == xalu_pkg::OP_SBB) & cf_ff};
            r = (d - sub) & m;
            cf = d < sub;
            of_n = ((d ^ s) & (d ^ r) & top) != 0;
            upd_szp = 1'b1;
         end
         xalu_pkg::OP_MUL: begin
            r = prod_v & m2;
            cf = (prod_v >> w) != 0;
            of_n = cf;
         end
         xalu_pkg::OP_IMUL: begin
            r = prod_v & m2;
            cf = ((((prod_v & top) != 0) ? (prod_v | ~m) : (prod_v & m)) != prod_v);
            of_n = cf;
         end
         xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV, xalu_pkg::OP_MOD, xalu_pkg::OP_IMOD: begin
            de = (dvs_ff == 32'd0);
            if (!de) begin
               if (op_ff == xalu_pkg::OP_DIV || op_ff == xalu_pkg::OP_IDIV)
                  r = quo_ff & m;
               else
                  r = rem_ff & m;
            end
         end
         xalu_pkg::OP_AND, xalu_pkg::OP_XOR, xalu_pkg::OP_OR: begin
            r = (op_ff == xalu_pkg::OP_AND) ? (d & s) :
                (op_ff == xalu_pkg::OP_XOR) ? (d ^ s) : (d | s);
            cf = 1'b0; of_n = 1'b0; upd_szp = 1'b1;
         end
         xalu_pkg::OP_SHL, xalu_pkg::OP_SAL: begin
            if (c == 5'd0) r = d;
            else begin
               wide = d << c;
               r = wide & m;
               cf = ((wide >> w) & 64'd1) != 0;
               if (c == 5'd1) of_n = ((r & top) != 0) ^ cf;
               upd_szp = 1'b1;
            end
         end
         xalu_pkg::OP_SHR: begin
            if (c == 5'd0) r = d;
            else begin
               r = (d >> c) & m;
               cf = ((d >> (c - 5'd1)) & 64'd1) != 0;
               if (c == 5'd1) of_n = (d & top) != 0;
               upd_szp = 1'b1;
            end
         end
         xalu_pkg::OP_SAR: begin
            if (c == 5'd0) r = d;
            else begin
               sar_v = 64'($signed(sx_d) >>> c);
               r = sar_v & m;
               cf = ((sx_d >> (c - 5'd1)) & 64'd1) != 0;
               of_n = 1'b0;
               upd_szp = 1'b1;
            end
         end
         default: r = '0;
      endcase
      upd_co = upd_szp || status.is_mul;
      pf = upd_szp ? ~^r[7:0] : pf_ff;
      zf = upd_szp ? ((r & m) == 0) : zf_ff;
      sf = upd_szp ? ((r & top) != 0) : sf_ff;
      if (!upd_co) begin
         cf = cf_ff; of_n = of_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_cmd; size_ff <= req_operand_size;
         src_ff <= req_src_value; dst_ff <= req_dest_value;
      end
      if (cmd.mul_step) begin
         prod_ff <= mul_p; mneg_ff <= mneg;
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= dneg ? ((64'd0 - dv) & m2) : dv;
         dvs_ff <= 32'(sneg ? ((64'd0 - s) & m) : s);
         dneg_ff <= dneg; sneg_ff <= sneg;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.div_fix) begin
         if (dneg_ff != sneg_ff) quo_ff <= 64'd0 - quo_ff;
         if (dneg_ff) rem_ff <= 64'd0 - rem_ff;
      end
      if (cmd.finish) begin
         res_ff <= r; de_ff <= de;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff <= 1'b0; pf_ff <= 1'b0; zf_ff <= 1'b0; sf_ff <= 1'b0; of_ff <= 1'b0;
      end else if (cmd.finish) begin
         cf_ff <= cf; pf_ff <= pf; zf_ff <= zf; sf_ff <= sf; of_ff <= of_n;
      end
   end

   assign rsp_result_value  = res_ff;
   assign rsp_carry_flag    = cf_ff;
   assign rsp_parity_flag   = pf_ff;
   assign rsp_zero_flag     = zf_ff;
   assign rsp_sign_flag     = sf_ff;
   assign rsp_overflow_flag = of_ff;
   assign rsp_divide_error  = de_ff;

endmodule
`default_nettype wire

FILE: rtl/xalu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xalu_ctrl
// Sequencer: one item at a time, through the multiply step or the divide steps
// where the op has them, then the flag update and the output handshake.
// ----------------------------------------------------------------------------
module xalu_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  xalu_pkg::status_type status,
   output xalu_pkg::cmd_type    cmd
);

   xalu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= xalu_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xalu_pkg::ST_IDLE: if (req_valid) state_in = xalu_pkg::ST_MULT;
         xalu_pkg::ST_MULT: begin
            if (status.is_div) state_in = xalu_pkg::ST_DIV;
            else               state_in = xalu_pkg::ST_FIN;
         end
         xalu_pkg::ST_DIV: if (status.div_last) state_in = xalu_pkg::ST_FIX;
         xalu_pkg::ST_FIX: state_in = xalu_pkg::ST_FIN;
         xalu_pkg::ST_FIN: state_in = xalu_pkg::ST_OUT;
         xalu_pkg::ST_OUT: if (rsp_ready) state_in = xalu_pkg::ST_IDLE;
         default: state_in = xalu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         xalu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         xalu_pkg::ST_MULT: begin
            cmd.mul_step = status.is_mul;
            cmd.div_init = status.is_div;
         end
         xalu_pkg::ST_DIV: cmd.div_step = 1'b1;
         xalu_pkg::ST_FIX: cmd.div_fix = 1'b1;
         xalu_pkg::ST_FIN: cmd.finish = 1'b1;
         xalu_pkg::ST_OUT: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/x86_integer_alu_with_flags_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_unit
// x86 integer ALU at 8, 16 or 32 bits with stored CF, PF, ZF, SF and OF.
// ----------------------------------------------------------------------------
// One item is in flight at a time. For add, logic, shift, mul and imul items
// the states run multiply, finish and output, and the result is valid in
// the output state (mul and imul register a 32x32 magnitude product in the
// multiply state). Division and modulo run a setup step, the bit-serial
// restoring divider that retires one quotient bit per cycle over a 64-bit
// dividend, and a sign-fix step before the finish and output states. The next
// item is taken the cycle after the result transfers out.
module x86_integer_alu_with_flags_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [4:0]  req_cmd,
   input  wire  [1:0]  req_operand_size,
   input  wire  [31:0] req_src_value,
   input  wire  [63:0] req_dest_value,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_result_value,
   output logic        rsp_carry_flag,
   output logic        rsp_parity_flag,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_divide_error
);

   xalu_pkg::cmd_type    cmd;
   xalu_pkg::status_type status;

   xalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   xalu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_operand_size  (req_operand_size),
      .req_src_value     (req_src_value),
      .req_dest_value    (req_dest_value),
      .rsp_result_value  (rsp_result_value),
      .rsp_carry_flag    (rsp_carry_flag),
      .rsp_parity_flag   (rsp_parity_flag),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_divide_error  (rsp_divide_error)
   );

endmodule
`default_nettype wire
